// ===== hdl/fcd_pkg.sv =====
// Package for the FLI frame chunk decoder: shared types and codes.
package fcd_pkg;

   localparam logic [1:0] CSR_DECODE_MODE  = 2'd0;
   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd2;

   localparam logic [1:0] MODE_BYTE_RUN   = 2'd0;
   localparam logic [1:0] MODE_LINE_DELTA = 2'd1;
   localparam logic [1:0] MODE_RAW_COPY   = 2'd2;

   localparam logic [1:0]  RESET_MODE   = MODE_BYTE_RUN;
   localparam logic [10:0] RESET_WIDTH  = 11'd320;
   localparam logic [10:0] RESET_HEIGHT = 11'd200;

   typedef enum logic [3:0] {
      PH_START   = 4'd0,
      PH_BR_LINE = 4'd1,
      PH_BR_CODE = 4'd2,
      PH_BR_LIT  = 4'd3,
      PH_BR_FILL = 4'd4,
      PH_DL_H0   = 4'd5,
      PH_DL_H1   = 4'd6,
      PH_DL_H2   = 4'd7,
      PH_DL_H3   = 4'd8,
      PH_DL_LINE = 4'd9,
      PH_DL_SKIP = 4'd10,
      PH_DL_SIZE = 4'd11,
      PH_DL_LIT  = 4'd12,
      PH_DL_FILL = 4'd13,
      PH_CP_PIX  = 4'd14,
      PH_DONE    = 4'd15
   } phase_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [10:0] width;
      logic [10:0] height;
   } cfg_type;

   typedef struct packed {
      logic        have;
      logic [9:0]  span_x;
      logic [9:0]  span_y;
      logic [7:0]  span_len;
      logic [7:0]  pixel_value;
      logic        chunk_done;
      logic        overflow;
   } result_type;

endpackage

// ===== hdl/fcd_parser.sv =====
// Subchunk byte parser: parse state registers, next-state logic and span generation.
module fcd_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          in_byte,
   input  logic                chunk_start,
   input  fcd_pkg::cfg_type    cfg,
   output fcd_pkg::result_type result
);

   fcd_pkg::phase_type phase_ff, phase_in, phase_cur, phase_sel;
   logic [10:0] col_ff, col_in, col_cur;
   logic [15:0] line_ff, line_in, line_cur;
   logic [7:0]  run_ff, run_in, run_cur;
   logic [7:0]  pkts_ff, pkts_in, pkts_cur;
   logic [15:0] lines_ff, lines_in, lines_cur;
   logic [7:0]  wlow_ff, wlow_in, wlow_cur;

   logic        start_fin;
   logic [7:0]  adv_amt;
   logic [11:0] col_sum;
   logic [10:0] col_adv;
   logic        col_at_w;
   logic [15:0] line_inc;
   logic        line_end_hit;
   logic [15:0] lines_dec;
   logic [7:0]  pkts_dec;
   logic [7:0]  run_dec;
   logic [7:0]  run_neg;
   logic [15:0] hdr_word;

   logic        span_req;
   logic [7:0]  span_n;
   logic        done_set;
   logic        br_eol;
   logic        dl_eop;
   logic        dl_eol;

   logic        span_drop;
   logic [11:0] span_end;
   logic        span_clip;

   // a new subchunk restarts from the reset state
   always_comb begin
      if (chunk_start) begin
         phase_cur = fcd_pkg::PH_START;
         col_cur   = '0;
         line_cur  = '0;
         run_cur   = '0;
         pkts_cur  = '0;
         lines_cur = '0;
         wlow_cur  = '0;
      end else begin
         phase_cur = phase_ff;
         col_cur   = col_ff;
         line_cur  = line_ff;
         run_cur   = run_ff;
         pkts_cur  = pkts_ff;
         lines_cur = lines_ff;
         wlow_cur  = wlow_ff;
      end
   end

   // mode dispatch on the first byte; the same byte then goes to the chosen phase
   always_comb begin
      phase_sel = phase_cur;
      start_fin = 1'b0;
      if (phase_cur == fcd_pkg::PH_START) begin
         case (cfg.mode)
            fcd_pkg::MODE_BYTE_RUN: begin
               if (cfg.height == '0) begin
                  phase_sel = fcd_pkg::PH_DONE;
                  start_fin = 1'b1;
               end else begin
                  phase_sel = fcd_pkg::PH_BR_LINE;
               end
            end
            fcd_pkg::MODE_LINE_DELTA: begin
               phase_sel = fcd_pkg::PH_DL_H0;
            end
            fcd_pkg::MODE_RAW_COPY: begin
               if (cfg.width == '0 || cfg.height == '0) begin
                  phase_sel = fcd_pkg::PH_DONE;
                  start_fin = 1'b1;
               end else begin
                  phase_sel = fcd_pkg::PH_CP_PIX;
               end
            end
            default: begin
               phase_sel = fcd_pkg::PH_DONE;
            end
         endcase
      end
   end

   always_comb begin
      case (phase_sel)
         fcd_pkg::PH_BR_LIT, fcd_pkg::PH_DL_LIT, fcd_pkg::PH_CP_PIX: adv_amt = 8'd1;
         fcd_pkg::PH_BR_FILL, fcd_pkg::PH_DL_FILL:                   adv_amt = run_cur;
         fcd_pkg::PH_DL_SKIP:                                        adv_amt = in_byte;
         default:                                                    adv_amt = 8'd0;
      endcase
   end

   assign col_sum      = {1'b0, col_cur} + {4'b0, adv_amt};
   assign col_adv      = col_sum[11] ? 11'h7FF : col_sum[10:0];
   assign col_at_w     = (col_adv >= cfg.width);
   assign line_inc     = line_cur + 16'd1;
   assign line_end_hit = (line_inc >= {5'b0, cfg.height});
   assign lines_dec    = lines_cur - 16'd1;
   assign pkts_dec     = pkts_cur - 8'd1;
   assign run_dec      = run_cur - 8'd1;
   assign run_neg      = 8'(9'd256 - {1'b0, in_byte});
   assign hdr_word     = {in_byte, wlow_cur};

   // next parse state
   always_comb begin
      phase_in = phase_sel;
      col_in   = col_cur;
      line_in  = line_cur;
      run_in   = run_cur;
      pkts_in  = pkts_cur;
      lines_in = lines_cur;
      wlow_in  = wlow_cur;
      span_req = 1'b0;
      span_n   = 8'd0;
      done_set = start_fin;
      br_eol   = 1'b0;
      dl_eop   = 1'b0;
      dl_eol   = 1'b0;
      case (phase_sel)
         fcd_pkg::PH_BR_LINE: begin
            col_in = '0;
            if (cfg.width == '0) begin
               br_eol = 1'b1;
            end else begin
               phase_in = fcd_pkg::PH_BR_CODE;
            end
         end
         fcd_pkg::PH_BR_CODE: begin
            if (in_byte[7]) begin
               run_in   = run_neg;
               phase_in = fcd_pkg::PH_BR_LIT;
            end else begin
               run_in   = in_byte;
               phase_in = fcd_pkg::PH_BR_FILL;
            end
         end
         fcd_pkg::PH_BR_LIT: begin
            span_req = 1'b1;
            span_n   = 8'd1;
            col_in   = col_adv;
            run_in   = run_dec;
            if (run_dec == '0) begin
               if (col_at_w) begin
                  br_eol = 1'b1;
               end else begin
                  phase_in = fcd_pkg::PH_BR_CODE;
               end
            end
         end
         fcd_pkg::PH_BR_FILL: begin
            span_req = (run_cur != '0);
            span_n   = run_cur;
            col_in   = col_adv;
            run_in   = '0;
            if (col_at_w) begin
               br_eol = 1'b1;
            end else begin
               phase_in = fcd_pkg::PH_BR_CODE;
            end
         end
         fcd_pkg::PH_DL_H0: begin
            wlow_in  = in_byte;
            phase_in = fcd_pkg::PH_DL_H1;
         end
         fcd_pkg::PH_DL_H1: begin
            line_in  = hdr_word;
            phase_in = fcd_pkg::PH_DL_H2;
         end
         fcd_pkg::PH_DL_H2: begin
            wlow_in  = in_byte;
            phase_in = fcd_pkg::PH_DL_H3;
         end
         fcd_pkg::PH_DL_H3: begin
            lines_in = hdr_word;
            col_in   = '0;
            if (hdr_word == '0) begin
               phase_in = fcd_pkg::PH_DONE;
               done_set = 1'b1;
            end else begin
               phase_in = fcd_pkg::PH_DL_LINE;
            end
         end
         fcd_pkg::PH_DL_LINE: begin
            col_in  = '0;
            pkts_in = in_byte;
            if (in_byte == '0) begin
               dl_eol = 1'b1;
            end else begin
               phase_in = fcd_pkg::PH_DL_SKIP;
            end
         end
         fcd_pkg::PH_DL_SKIP: begin
            col_in   = col_adv;
            phase_in = fcd_pkg::PH_DL_SIZE;
         end
         fcd_pkg::PH_DL_SIZE: begin
            if (in_byte == '0) begin
               dl_eop = 1'b1;
            end else if (!in_byte[7]) begin
               run_in   = in_byte;
               phase_in = fcd_pkg::PH_DL_LIT;
            end else begin
               run_in   = run_neg;
               phase_in = fcd_pkg::PH_DL_FILL;
            end
         end
         fcd_pkg::PH_DL_LIT: begin
            span_req = 1'b1;
            span_n   = 8'd1;
            col_in   = col_adv;
            run_in   = run_dec;
            if (run_dec == '0) begin
               dl_eop = 1'b1;
            end
         end
         fcd_pkg::PH_DL_FILL: begin
            span_req = 1'b1;
            span_n   = run_cur;
            col_in   = col_adv;
            run_in   = '0;
            dl_eop   = 1'b1;
         end
         fcd_pkg::PH_CP_PIX: begin
            span_req = 1'b1;
            span_n   = 8'd1;
            col_in   = col_adv;
            if (col_at_w) begin
               col_in  = '0;
               line_in = line_inc;
               if (line_end_hit) begin
                  phase_in = fcd_pkg::PH_DONE;
                  done_set = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase

      if (br_eol) begin
         col_in  = '0;
         line_in = line_inc;
         if (line_end_hit) begin
            phase_in = fcd_pkg::PH_DONE;
            done_set = 1'b1;
         end else begin
            phase_in = fcd_pkg::PH_BR_LINE;
         end
      end

      if (dl_eop) begin
         pkts_in = pkts_dec;
         if (pkts_dec == '0) begin
            dl_eol = 1'b1;
         end else begin
            phase_in = fcd_pkg::PH_DL_SKIP;
         end
      end

      if (dl_eol) begin
         col_in   = '0;
         line_in  = line_inc;
         lines_in = lines_dec;
         if (lines_dec == '0) begin
            phase_in = fcd_pkg::PH_DONE;
            done_set = 1'b1;
         end else begin
            phase_in = fcd_pkg::PH_DL_LINE;
         end
      end
   end

   assign span_drop = (line_cur >= {5'b0, cfg.height}) || (col_cur >= cfg.width);
   assign span_end  = {1'b0, col_cur} + {4'b0, span_n};
   assign span_clip = (span_end > {1'b0, cfg.width});

   // result of this byte
   always_comb begin
      result             = '0;
      result.have        = span_req || done_set;
      result.chunk_done  = done_set;
      if (span_req) begin
         if (span_drop) begin
            result.overflow = 1'b1;
         end else begin
            result.span_x      = col_cur[9:0];
            result.span_y      = line_cur[9:0];
            result.pixel_value = in_byte;
            result.span_len    = span_clip ? 8'(cfg.width - col_cur) : span_n;
            result.overflow    = span_clip;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= fcd_pkg::PH_START;
         col_ff   <= '0;
         line_ff  <= '0;
         run_ff   <= '0;
         pkts_ff  <= '0;
         lines_ff <= '0;
         wlow_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         col_ff   <= col_in;
         line_ff  <= line_in;
         run_ff   <= run_in;
         pkts_ff  <= pkts_in;
         lines_ff <= lines_in;
         wlow_ff  <= wlow_in;
      end
   end

endmodule

// ===== hdl/fli_frame_chunk_decoder.sv =====
// A byte in the input register has its span transaction registered and driven on rsp_.
// One byte per cycle without stalls; the parser state loop is a single registered step.
// A stalled result register holds the input register, which then deasserts req_ready.
// Reset (synchronous, active high) clears the parser, valid flags and registers:
// byte-run mode, width 320, height 200.
module fli_frame_chunk_decoder #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_chunk_start,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [9:0]  rsp_span_x,
   output logic [9:0]  rsp_span_y,
   output logic [7:0]  rsp_span_len,
   output logic [7:0]  rsp_pixel_value,
   output logic        rsp_chunk_done,
   output logic        rsp_overflow,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data
);

   logic [1:0]  mode_ff;
   logic [10:0] width_ff;
   logic [10:0] height_ff;
   fcd_pkg::cfg_type cfg;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_start_ff;
   logic        advance;

   fcd_pkg::result_type res;
   fcd_pkg::result_type rsp_data_ff;
   logic        rsp_valid_ff, rsp_valid_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= fcd_pkg::RESET_MODE;
         width_ff  <= fcd_pkg::RESET_WIDTH;
         height_ff <= fcd_pkg::RESET_HEIGHT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            fcd_pkg::CSR_DECODE_MODE:  mode_ff   <= csr_data[1:0];
            fcd_pkg::CSR_FRAME_WIDTH:  width_ff  <= csr_data;
            fcd_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.mode   = mode_ff;
      cfg.width  = ({2'b0, width_ff} > MAX_WIDTH) ? 11'(MAX_WIDTH) : width_ff;
      cfg.height = ({2'b0, height_ff} > MAX_HEIGHT) ? 11'(MAX_HEIGHT) : height_ff;
   end

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff  <= req_in_byte;
         in_start_ff <= req_chunk_start;
      end
   end

   fcd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .in_byte     (in_byte_ff),
      .chunk_start (in_start_ff),
      .cfg         (cfg),
      .result      (res)
   );

   always_comb begin
      if (advance && res.have) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res.have) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_span_x      = rsp_data_ff.span_x;
   assign rsp_span_y      = rsp_data_ff.span_y;
   assign rsp_span_len    = rsp_data_ff.span_len;
   assign rsp_pixel_value = rsp_data_ff.pixel_value;
   assign rsp_chunk_done  = rsp_data_ff.chunk_done;
   assign rsp_overflow    = rsp_data_ff.overflow;

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_span_len <= 8'd128)
      else $error("span length above 128");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_span_len == 8'd0 |->
         rsp_span_x == 10'd0 && rsp_span_y == 10'd0 && rsp_pixel_value == 8'd0)
      else $error("status-only transaction carries span fields");

   a_status_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_span_len == 8'd0 |-> rsp_chunk_done || rsp_overflow)
      else $error("empty transaction without done or overflow");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_start_ff))
      else $error("input register lost a stalled byte");

endmodule

// ===== tb/sv/tb_fli_frame_chunk_decoder.sv =====
// Self-checking testbench for fli_frame_chunk_decoder: subchunk bytes in, predicted spans checked.
`timescale 1ns / 1ps

module tb_fli_frame_chunk_decoder;

   localparam int FRAME_MAX_W = 1024;
   localparam int FRAME_MAX_H = 1024;
   localparam int CYCLE_LIMIT = 500000;
   localparam logic [1:0] MODE_UNDEFINED = 2'd3;

   typedef struct packed {
      logic       first;
      logic [7:0] data;
   } body_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'd0;
   logic        req_chunk_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [9:0]  rsp_span_x;
   logic [9:0]  rsp_span_y;
   logic [7:0]  rsp_span_len;
   logic [7:0]  rsp_pixel_value;
   logic        rsp_chunk_done;
   logic        rsp_overflow;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = fcd_pkg::CSR_DECODE_MODE;
   logic [10:0] csr_data = 11'd0;

   fli_frame_chunk_decoder #(
      .MAX_WIDTH  (FRAME_MAX_W),
      .MAX_HEIGHT (FRAME_MAX_H)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .req_chunk_start (req_chunk_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_span_x      (rsp_span_x),
      .rsp_span_y      (rsp_span_y),
      .rsp_span_len    (rsp_span_len),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_chunk_done  (rsp_chunk_done),
      .rsp_overflow    (rsp_overflow),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   body_byte_type        body_bytes[$];
   fcd_pkg::result_type  spans_due[$];
   fcd_pkg::result_type  span_want;
   body_byte_type        next_byte;

   logic start_pending = 1'b0;
   logic calm = 1'b1;
   logic long_hold = 1'b0;
   logic hold_used = 1'b0;
   logic req_fire = 1'b0;
   int   send_gap = 0;
   int   stall_left = 0;
   int   hold_left = 0;
   int   cycle_count = 0;
   int   fail_count = 0;
   int   bytes_taken = 0;
   int   spans_checked = 0;
   int   chunks_closed = 0;
   int   spans_clipped = 0;

   // mirror of the decoder registers and parser
   logic [1:0]  mode_reg = fcd_pkg::RESET_MODE;
   logic [10:0] width_reg = fcd_pkg::RESET_WIDTH;
   logic [10:0] height_reg = fcd_pkg::RESET_HEIGHT;
   fcd_pkg::phase_type parse_ph = fcd_pkg::PH_START;
   logic [10:0] col_pos = '0;
   logic [15:0] row_pos = '0;
   logic [15:0] rows_left = '0;
   logic [7:0]  run_cnt = '0;
   logic [7:0]  pkt_cnt = '0;
   logic [7:0]  low_byte = '0;
   fcd_pkg::result_type cur_span;

   function automatic void restart_parser();
      parse_ph = fcd_pkg::PH_START;
      col_pos = '0;
      row_pos = '0;
      rows_left = '0;
      run_cnt = '0;
      pkt_cnt = '0;
      low_byte = '0;
   endfunction

   function automatic void close_chunk();
      cur_span.chunk_done = 1'b1;
      parse_ph = fcd_pkg::PH_DONE;
   endfunction

   function automatic void step_column(input int n);
      int c;
      c = col_pos + n;
      col_pos = (c > 2047) ? 11'd2047 : 11'(c);
   endfunction

   function automatic void emit_span(input int n, input logic [7:0] v, input int w, input int h);
      cur_span.have = 1'b1;
      if (row_pos >= h || col_pos >= w) begin
         cur_span.overflow = 1'b1;
         return;
      end
      cur_span.span_x = col_pos[9:0];
      cur_span.span_y = row_pos[9:0];
      cur_span.pixel_value = v;
      cur_span.span_len = 8'(n);
      if (col_pos + n > w) begin
         cur_span.span_len = 8'(w - col_pos);
         cur_span.overflow = 1'b1;
      end
   endfunction

   function automatic void br_line_done(input int h);
      col_pos = '0;
      row_pos = row_pos + 16'd1;
      if (row_pos >= h) close_chunk();
      else parse_ph = fcd_pkg::PH_BR_LINE;
   endfunction

   function automatic void br_run_done(input int w, input int h);
      if (col_pos >= w) br_line_done(h);
      else parse_ph = fcd_pkg::PH_BR_CODE;
   endfunction

   function automatic void dl_line_done();
      row_pos = row_pos + 16'd1;
      rows_left = rows_left - 16'd1;
      col_pos = '0;
      if (rows_left == 0) close_chunk();
      else parse_ph = fcd_pkg::PH_DL_LINE;
   endfunction

   function automatic void dl_packet_done();
      pkt_cnt = pkt_cnt - 8'd1;
      if (pkt_cnt == 0) dl_line_done();
      else parse_ph = fcd_pkg::PH_DL_SKIP;
   endfunction

   // advance the parser by one body byte, queue the span it yields
   function automatic void decode_byte(input logic [7:0] b, input logic first);
      int w, h;
      w = (int'(width_reg) > FRAME_MAX_W) ? FRAME_MAX_W : int'(width_reg);
      h = (int'(height_reg) > FRAME_MAX_H) ? FRAME_MAX_H : int'(height_reg);
      cur_span = '0;
      if (first) restart_parser();
      if (parse_ph == fcd_pkg::PH_START) begin
         case (mode_reg)
            fcd_pkg::MODE_BYTE_RUN: begin
               if (h == 0) close_chunk();
               else parse_ph = fcd_pkg::PH_BR_LINE;
            end
            fcd_pkg::MODE_LINE_DELTA: parse_ph = fcd_pkg::PH_DL_H0;
            fcd_pkg::MODE_RAW_COPY: begin
               if (w == 0 || h == 0) close_chunk();
               else parse_ph = fcd_pkg::PH_CP_PIX;
            end
            default: parse_ph = fcd_pkg::PH_DONE;
         endcase
      end
      if (!cur_span.chunk_done) begin
         case (parse_ph)
            fcd_pkg::PH_BR_LINE: begin
               col_pos = '0;
               if (w == 0) br_line_done(h);
               else parse_ph = fcd_pkg::PH_BR_CODE;
            end
            fcd_pkg::PH_BR_CODE: begin
               if (b >= 8'h80) begin
                  run_cnt = 8'(256 - b);
                  parse_ph = fcd_pkg::PH_BR_LIT;
               end else begin
                  run_cnt = b;
                  parse_ph = fcd_pkg::PH_BR_FILL;
               end
            end
            fcd_pkg::PH_BR_LIT: begin
               emit_span(1, b, w, h);
               step_column(1);
               run_cnt = run_cnt - 8'd1;
               if (run_cnt == 0) br_run_done(w, h);
            end
            fcd_pkg::PH_BR_FILL: begin
               if (run_cnt != 0) emit_span(int'(run_cnt), b, w, h);
               step_column(int'(run_cnt));
               run_cnt = '0;
               br_run_done(w, h);
            end
            fcd_pkg::PH_DL_H0: begin
               low_byte = b;
               parse_ph = fcd_pkg::PH_DL_H1;
            end
            fcd_pkg::PH_DL_H1: begin
               row_pos = {b, low_byte};
               parse_ph = fcd_pkg::PH_DL_H2;
            end
            fcd_pkg::PH_DL_H2: begin
               low_byte = b;
               parse_ph = fcd_pkg::PH_DL_H3;
            end
            fcd_pkg::PH_DL_H3: begin
               rows_left = {b, low_byte};
               col_pos = '0;
               if (rows_left == 0) close_chunk();
               else parse_ph = fcd_pkg::PH_DL_LINE;
            end
            fcd_pkg::PH_DL_LINE: begin
               col_pos = '0;
               pkt_cnt = b;
               if (b == 0) dl_line_done();
               else parse_ph = fcd_pkg::PH_DL_SKIP;
            end
            fcd_pkg::PH_DL_SKIP: begin
               step_column(int'(b));
               parse_ph = fcd_pkg::PH_DL_SIZE;
            end
            fcd_pkg::PH_DL_SIZE: begin
               if (b == 0) begin
                  dl_packet_done();
               end else if (b < 8'h80) begin
                  run_cnt = b;
                  parse_ph = fcd_pkg::PH_DL_LIT;
               end else begin
                  run_cnt = 8'(256 - b);
                  parse_ph = fcd_pkg::PH_DL_FILL;
               end
            end
            fcd_pkg::PH_DL_LIT: begin
               emit_span(1, b, w, h);
               step_column(1);
               run_cnt = run_cnt - 8'd1;
               if (run_cnt == 0) dl_packet_done();
            end
            fcd_pkg::PH_DL_FILL: begin
               emit_span(int'(run_cnt), b, w, h);
               step_column(int'(run_cnt));
               run_cnt = '0;
               dl_packet_done();
            end
            fcd_pkg::PH_CP_PIX: begin
               emit_span(1, b, w, h);
               step_column(1);
               if (col_pos >= w) begin
                  col_pos = '0;
                  row_pos = row_pos + 16'd1;
                  if (row_pos >= h) close_chunk();
               end
            end
            default: ;
         endcase
      end
      if (cur_span.have || cur_span.chunk_done) spans_due.push_back(cur_span);
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH cycle %0d: %s", cycle_count, what);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   // subchunk byte generators
   function automatic void queue_byte(input int data);
      body_byte_type it;
      it.data = 8'(data);
      it.first = start_pending;
      start_pending = 1'b0;
      body_bytes.push_back(it);
   endfunction

   function automatic void gen_byte_run(input int w, input int h);
      int lines, ln, col, n, room;
      lines = (h <= 6) ? h : $urandom_range(1, 6);
      if (lines == 0) queue_byte($urandom_range(0, 255));
      for (ln = 0; ln < lines; ln++) begin
         queue_byte($urandom_range(0, 255));
         col = 0;
         while (col < w) begin
            room = w - col;
            if ($urandom_range(0, 1) == 0) begin
               n = $urandom_range(1, (room < 8) ? room : 8);
               if ($urandom_range(0, 9) == 0) n = $urandom_range(1, 128);
               queue_byte(256 - n);
               repeat (n) queue_byte($urandom_range(0, 255));
            end else begin
               n = $urandom_range(0, (room < 127) ? room : 127);
               if ($urandom_range(0, 9) == 0) n = $urandom_range(0, 127);
               queue_byte(n);
               queue_byte($urandom_range(0, 255));
            end
            col += n;
         end
      end
   endfunction

   function automatic void gen_line_delta(input int w, input int h);
      int first_line, count, lines, ln, pk, s, n;
      first_line = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, (h < 8) ? h : 8);
      count = $urandom_range(1, 4);
      case ($urandom_range(0, 9))
         0: count = 0;
         1: count = $urandom_range(0, 65535);
         default: ;
      endcase
      queue_byte(first_line & 8'hFF);
      queue_byte(first_line >> 8);
      queue_byte(count & 8'hFF);
      queue_byte(count >> 8);
      lines = (count < 5) ? count : 4;
      for (ln = 0; ln < lines; ln++) begin
         pk = $urandom_range(0, 4);
         queue_byte(pk);
         repeat (pk) begin
            if ($urandom_range(0, 5) == 0) queue_byte($urandom_range(0, 255));
            else queue_byte($urandom_range(0, (w / 4 < 255) ? w / 4 : 255));
            case ($urandom_range(0, 5))
               0: queue_byte(0);
               1, 2, 3: begin
                  s = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 8);
                  queue_byte(s);
                  repeat (s) queue_byte($urandom_range(0, 255));
               end
               default: begin
                  n = $urandom_range(1, 128);
                  queue_byte(256 - n);
                  queue_byte($urandom_range(0, 255));
               end
            endcase
         end
      end
   endfunction

   function automatic void gen_raw_copy(input int w, input int h);
      int total;
      total = w * h;
      if (total == 0) total = 1;
      if (total > 240) total = $urandom_range(1, 240);
      repeat (total) queue_byte($urandom_range(0, 255));
   endfunction

   function automatic void gen_noise();
      repeat ($urandom_range(4, 24)) begin
         start_pending = ($urandom_range(0, 7) == 0);
         queue_byte($urandom_range(0, 255));
      end
   endfunction

   task automatic write_reg(input logic [1:0] idx, input logic [10:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         fcd_pkg::CSR_DECODE_MODE:  mode_reg = value[1:0];
         fcd_pkg::CSR_FRAME_WIDTH:  width_reg = value;
         fcd_pkg::CSR_FRAME_HEIGHT: height_reg = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [1:0] mode, input logic [10:0] w, input logic [10:0] h);
      write_reg(fcd_pkg::CSR_DECODE_MODE, {9'd0, mode});
      write_reg(fcd_pkg::CSR_FRAME_WIDTH, w);
      write_reg(fcd_pkg::CSR_FRAME_HEIGHT, h);
   endtask

   // sender idle, every span back, then a settle wait for bytes that yield nothing
   task automatic drain_decoder();
      while (body_bytes.size() != 0 || req_valid) @(posedge clock);
      while (spans_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   always @(posedge clock) begin
      req_fire = req_valid && req_ready && !reset;
      if (req_fire) begin
         decode_byte(req_in_byte, req_chunk_start);
         bytes_taken++;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (send_gap != 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 13);
            req_valid <= 1'b0;
         end else if (body_bytes.size() != 0) begin
            next_byte = body_bytes.pop_front();
            req_valid <= 1'b1;
            req_in_byte <= next_byte.data;
            req_chunk_start <= next_byte.first;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (long_hold && !hold_used) begin
         hold_used = 1'b1;
         hold_left = 79;
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 13);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (spans_due.size() == 0) begin
            report_mismatch("span transaction with nothing expected");
         end else begin
            span_want = spans_due.pop_front();
            check_field("span_x", 16'(rsp_span_x), 16'(span_want.span_x));
            check_field("span_y", 16'(rsp_span_y), 16'(span_want.span_y));
            check_field("span_len", 16'(rsp_span_len), 16'(span_want.span_len));
            check_field("pixel_value", 16'(rsp_pixel_value), 16'(span_want.pixel_value));
            check_field("chunk_done", 16'(rsp_chunk_done), 16'(span_want.chunk_done));
            check_field("overflow", 16'(rsp_overflow), 16'(span_want.overflow));
            spans_checked++;
            if (span_want.chunk_done) chunks_closed++;
            if (span_want.overflow) spans_clipped++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout at cycle %0d with %0d spans outstanding", cycle_count,
                  spans_due.size());
         $display("fli_frame_chunk_decoder test failed");
         $finish;
      end
   end

   initial begin
      int directed[$];
      int random_bytes, pick_w, pick_h, we, he, nchunks, c, mark, k;
      logic [1:0] pick_mode;

      restart_parser();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // byte-run: literals, empty repeat, clipped fill, literal run past width, end
      set_config(fcd_pkg::MODE_BYTE_RUN, 11'd4, 11'd2);
      directed = '{8'h33, 8'hFE, 8'h00, 8'hFF, 8'h00, 8'h55, 8'h7F, 8'hAA,
                   8'h01, 8'hFA, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h12};
      start_pending = 1'b1;
      foreach (directed[i]) queue_byte(directed[i]);
      drain_decoder();
      // line delta with zero line count
      write_reg(fcd_pkg::CSR_DECODE_MODE, {9'd0, fcd_pkg::MODE_LINE_DELTA});
      start_pending = 1'b1;
      repeat (4) queue_byte(0);
      drain_decoder();
      // undefined mode ignores the subchunk
      write_reg(fcd_pkg::CSR_DECODE_MODE, {9'd0, MODE_UNDEFINED});
      start_pending = 1'b1;
      queue_byte(8'hFF);
      drain_decoder();
      // raw copy into an empty frame
      set_config(fcd_pkg::MODE_RAW_COPY, 11'd0, 11'd0);
      start_pending = 1'b1;
      queue_byte(8'h80);
      drain_decoder();

      // output held off while a copy frame streams in
      calm = 1'b1;
      set_config(fcd_pkg::MODE_RAW_COPY, 11'd16, 11'd8);
      start_pending = 1'b1;
      gen_raw_copy(16, 8);
      long_hold = 1'b1;

      random_bytes = 0;
      while (random_bytes < 1600) begin
         case ($urandom_range(0, 9))
            0, 1, 2: pick_mode = fcd_pkg::MODE_BYTE_RUN;
            3, 4, 5: pick_mode = fcd_pkg::MODE_LINE_DELTA;
            9:       pick_mode = MODE_UNDEFINED;
            default: pick_mode = fcd_pkg::MODE_RAW_COPY;
         endcase
         case ($urandom_range(0, 15))
            0: pick_w = 0;
            1: pick_w = 1;
            2: pick_w = 1024;
            3: pick_w = 2047;
            4: pick_w = $urandom_range(1025, 2046);
            default: pick_w = $urandom_range(2, 40);
         endcase
         case ($urandom_range(0, 11))
            0: pick_h = 0;
            1: pick_h = 1;
            2: pick_h = 1024;
            3: pick_h = 2047;
            default: pick_h = $urandom_range(2, 6);
         endcase
         we = (pick_w > FRAME_MAX_W) ? FRAME_MAX_W : pick_w;
         he = (pick_h > FRAME_MAX_H) ? FRAME_MAX_H : pick_h;
         drain_decoder();
         calm = (random_bytes > 1350) || ($urandom_range(0, 4) == 0);
         set_config(pick_mode, 11'(pick_w), 11'(pick_h));
         nchunks = $urandom_range(1, 3);
         for (c = 0; c < nchunks; c++) begin
            mark = body_bytes.size();
            // sometimes carry on the open subchunk under the new settings
            start_pending = !(c == 0 && $urandom_range(0, 7) == 0);
            case (pick_mode)
               fcd_pkg::MODE_BYTE_RUN:   gen_byte_run(we, he);
               fcd_pkg::MODE_LINE_DELTA: gen_line_delta(we, he);
               fcd_pkg::MODE_RAW_COPY:   gen_raw_copy(we, he);
               default:                  gen_noise();
            endcase
            if ($urandom_range(0, 7) == 0) begin
               k = $urandom_range(1, 8);
               repeat (k) if (body_bytes.size() > mark + 1) void'(body_bytes.pop_back());
            end
            if ($urandom_range(0, 5) == 0)
               repeat ($urandom_range(1, 3)) queue_byte($urandom_range(0, 255));
         end
         if ($urandom_range(0, 9) == 0) gen_noise();
         if (pick_mode != MODE_UNDEFINED) random_bytes += body_bytes.size();
      end

      drain_decoder();
      $display("covered %0d body bytes over byte-run, line-delta, raw copy and undefined modes",
               bytes_taken);
      $display("checked %0d span transactions: %0d closed a subchunk, %0d clipped or dropped",
               spans_checked, chunks_closed, spans_clipped);
      if (fail_count == 0) begin
         $display("fli_frame_chunk_decoder test passed");
      end else begin
         $display("fli_frame_chunk_decoder test failed");
      end
      $finish;
   end

endmodule
